// ===== rtl/core/rgbn_pkg.sv =====
package rgbn_pkg;

    // channel and datapath widths
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int SQ_W        = 2 * CH_W;
    localparam int SUMSQ_W     = 18;
    localparam int FRAC_W      = 8;
    localparam int RAD_W       = SUMSQ_W + 2 * FRAC_W;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int NUM_W       = 26;
    localparam int DEN_W       = ROOT_W + 1;
    localparam int Q_W         = CH_W + 1;

    // pipeline shape
    localparam int SQRT_STEPS     = ROOT_W;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
    localparam int DIV_STEPS      = Q_W;
    localparam int DIV_PER_STAGE  = 2;
    localparam int DIV_STAGES     = 1 + (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int PIPE_DEPTH     = 1 + SQRT_STAGES + DIV_STAGES;
    localparam int OCC_W          = $clog2(PIPE_DEPTH + 1);

    // scale constants
    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [CH_W+FRAC_W+1:0] NUM_SCALE = 18'(2 * 255 * (1 << FRAC_W));

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
    } result_t;

    typedef struct packed {
        pixel_t             pix;
        logic [SUMSQ_W-1:0] sumsq;
    } sq_item_t;

    typedef struct packed {
        pixel_t            pix;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic                          black;
        logic [DEN_W-1:0]              den;
        logic [NUM_CH-1:0][NUM_W-1:0]  rem;
        logic [NUM_CH-1:0][Q_W-1:0]    quo;
    } div_state_t;

    // one digit of the square root: bring in the next radicand pair
    function automatic sqrt_state_t sqrt_step(sqrt_state_t st);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        sqrt_state_t      nx;
        nx    = st;
        cur   = {st.rem, st.rad[RAD_W-1 -: 2]};
        trial = {1'b0, st.root, 2'b01};
        nx.rad = {st.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            nx.rem  = REM_W'(cur - trial);
            nx.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nx.rem  = cur[REM_W-1:0];
            nx.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    // one quotient bit at position k for every channel
    function automatic div_state_t div_step(div_state_t st, int k);
        logic [NUM_W:0] dsh;
        div_state_t     nx;
        nx  = st;
        dsh = (NUM_W+1)'(st.den) << k;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if ({1'b0, st.rem[c]} >= dsh)
            begin
                nx.rem[c]    = st.rem[c] - dsh[NUM_W-1:0];
                nx.quo[c][k] = 1'b1;
            end
        end
        return nx;
    endfunction

endpackage

// ===== rtl/core/rgb_unit_vector_normalize.sv =====
// RGB unit-vector normalization: each pixel's color vector is scaled so that
// its Euclidean length maps to 255, each channel rounded and clipped to 0..255.
// A black pixel gives an all-zero result.
//
// Channels: pixel_valid/pixel_ready/pixel carries one RGB request, and
// result_valid/result_ready/result returns one normalized pixel per request,
// in order. A request moves on a clock edge with valid and ready both high.
//
// Throughput: one pixel per clock while result_ready is high. The pipeline
// has 16 register stages: 1 squaring stage, 9 square-root stages (up to two
// root bits each) and 6 divider stages (operand setup, then up to two quotient
// bits each).
//
// Reset (rst_n low, asynchronous) empties the pipeline; no other state exists.
// When the receiver stalls, full stages hold their data and empty stages keep
// filling, so pixel_ready drops only once every stage holds a pixel.
module rgb_unit_vector_normalize (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  rgbn_pkg::pixel_t  pixel,
    output logic              result_valid,
    input  logic              result_ready,
    output rgbn_pkg::result_t result
);
    import rgbn_pkg::*;

    logic        sq_valid;
    logic        sq_ready;
    sq_item_t    sq;
    logic        root_valid;
    logic        root_ready;
    sqrt_state_t root;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    // squares and sum
    rgbn_sumsq u_sumsq (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .sq_valid    (sq_valid),
        .sq_ready    (sq_ready),
        .sq          (sq)
    );

    // vector length with 8 fraction bits
    rgbn_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .sq_valid   (sq_valid),
        .sq_ready   (sq_ready),
        .sq         (sq),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root)
    );

    // per-channel rounded division and clipping
    rgbn_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .root_valid   (root_valid),
        .root_ready   (root_ready),
        .root         (root),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // pixels in flight
    always_comb
    begin
        occ_next = occ_reg;
        if (pixel_valid && pixel_ready)
        begin
            occ_next = occ_next + OCC_W'(1);
        end
        if (result_valid && result_ready)
        begin
            occ_next = occ_next - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // never more pixels in flight than pipeline stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(PIPE_DEPTH))
        else $error("pipeline holds more pixels than stages");

    // a result only appears for an accepted pixel
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> occ_reg != '0)
        else $error("result without a pixel in flight");

    // input backs up only when the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> (result_valid && !result_ready))
        else $error("input stalled while output is free");

    // a full pipeline cannot accept
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == OCC_W'(PIPE_DEPTH) && !result_ready) |-> !pixel_ready)
        else $error("full pipeline accepted a pixel");

endmodule

// ===== rtl/core/rgbn_sumsq.sv =====
module rgbn_sumsq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  rgbn_pkg::pixel_t  pixel,
    output logic              sq_valid,
    input  logic              sq_ready,
    output rgbn_pkg::sq_item_t sq
);
    import rgbn_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    sq_item_t data_reg;
    sq_item_t data_next;
    logic     adv;
    logic [SQ_W-1:0] sq_r;
    logic [SQ_W-1:0] sq_g;
    logic [SQ_W-1:0] sq_b;

    // stage moves when empty or when the next stage takes its request
    assign adv         = !valid_reg || sq_ready;
    assign pixel_ready = adv;

    // three squares and their exact sum
    always_comb
    begin
        sq_r = SQ_W'(pixel.red_in) * SQ_W'(pixel.red_in);
        sq_g = SQ_W'(pixel.green_in) * SQ_W'(pixel.green_in);
        sq_b = SQ_W'(pixel.blue_in) * SQ_W'(pixel.blue_in);
        data_next = data_reg;
        if (adv && pixel_valid)
        begin
            data_next.pix   = pixel;
            data_next.sumsq = SUMSQ_W'(sq_r) + SUMSQ_W'(sq_g) + SUMSQ_W'(sq_b);
        end
        valid_next = adv ? pixel_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign sq_valid = valid_reg;
    assign sq       = data_reg;

endmodule

// ===== rtl/core/rgbn_sqrt.sv =====
module rgbn_sqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sq_valid,
    output logic                  sq_ready,
    input  rgbn_pkg::sq_item_t    sq,
    output logic                  root_valid,
    input  logic                  root_ready,
    output rgbn_pkg::sqrt_state_t root
);
    import rgbn_pkg::*;

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [SQRT_STAGES-1:0] valid_next;
    logic [SQRT_STAGES-1:0] prev_valid;
    logic [SQRT_STAGES:0]   adv;
    sqrt_state_t            data_reg  [SQRT_STAGES];
    sqrt_state_t            data_next [SQRT_STAGES];
    sqrt_state_t            stage_in  [SQRT_STAGES];
    sqrt_state_t            first_in;

    assign adv[SQRT_STAGES] = root_ready;
    assign sq_ready         = adv[0];

    // radicand is the sum of squares with the fraction bits appended
    always_comb
    begin
        first_in     = '0;
        first_in.pix = sq.pix;
        first_in.rad = {sq.sumsq, (2 * FRAC_W)'(0)};
    end

    assign stage_in[0]   = first_in;
    assign prev_valid[0] = sq_valid;

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        if (s > 0)
        begin : g_link
            assign stage_in[s]   = data_reg[s-1];
            assign prev_valid[s] = valid_reg[s-1];
        end

        assign adv[s]        = !valid_reg[s] || adv[s+1];
        assign valid_next[s] = adv[s] ? prev_valid[s] : valid_reg[s];

        // up to two root digits per stage, the last stage takes one
        always_comb
        begin
            sqrt_state_t st;
            st = stage_in[s];
            for (int j = 0; j < SQRT_PER_STAGE; j++)
            begin
                if (s * SQRT_PER_STAGE + j < SQRT_STEPS)
                begin
                    st = sqrt_step(st);
                end
            end
            data_next[s] = (adv[s] && prev_valid[s]) ? st : data_reg[s];
        end

        always_ff @(posedge clk)
        begin
            data_reg[s] <= data_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign root_valid = valid_reg[SQRT_STAGES-1];
    assign root       = data_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/core/rgbn_div.sv =====
module rgbn_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  root_valid,
    output logic                  root_ready,
    input  rgbn_pkg::sqrt_state_t root,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rgbn_pkg::result_t     result
);
    import rgbn_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] valid_next;
    logic [DIV_STAGES-1:0] prev_valid;
    logic [DIV_STAGES:0]   adv;
    div_state_t            data_reg  [DIV_STAGES];
    div_state_t            data_next [DIV_STAGES];
    div_state_t            stage_in  [DIV_STAGES];
    div_state_t            init;
    logic [NUM_CH-1:0][CH_W-1:0] chan;
    logic [NUM_CH-1:0][CH_W-1:0] scaled;

    assign adv[DIV_STAGES] = result_ready;
    assign root_ready      = adv[0];

    // numerators 2*255*c*256 + len, divisor 2*len
    always_comb
    begin
        chan[0]    = root.pix.red_in;
        chan[1]    = root.pix.green_in;
        chan[2]    = root.pix.blue_in;
        init       = '0;
        init.black = (root.root == '0);
        init.den   = {root.root, 1'b0};
        for (int c = 0; c < NUM_CH; c++)
        begin
            init.rem[c] = NUM_W'(chan[c]) * NUM_W'(NUM_SCALE) + NUM_W'(root.root);
        end
    end

    assign stage_in[0]   = init;
    assign prev_valid[0] = root_valid;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        if (s > 0)
        begin : g_link
            assign stage_in[s]   = data_reg[s-1];
            assign prev_valid[s] = valid_reg[s-1];
        end

        assign adv[s]        = !valid_reg[s] || adv[s+1];
        assign valid_next[s] = adv[s] ? prev_valid[s] : valid_reg[s];

        // first stage just registers operands, the rest take up to two quotient bits
        always_comb
        begin
            div_state_t st;
            st = stage_in[s];
            if (s > 0)
            begin
                for (int j = 0; j < DIV_PER_STAGE; j++)
                begin
                    if ((s - 1) * DIV_PER_STAGE + j < DIV_STEPS)
                    begin
                        st = div_step(st, DIV_STEPS - 1 - ((s - 1) * DIV_PER_STAGE + j));
                    end
                end
            end
            data_next[s] = (adv[s] && prev_valid[s]) ? st : data_reg[s];
        end

        always_ff @(posedge clk)
        begin
            data_reg[s] <= data_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // saturate, and force black pixels to zero
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (data_reg[DIV_STAGES-1].black)
            begin
                scaled[c] = '0;
            end
            else if (data_reg[DIV_STAGES-1].quo[c] > Q_W'(FULL_SCALE))
            begin
                scaled[c] = FULL_SCALE;
            end
            else
            begin
                scaled[c] = data_reg[DIV_STAGES-1].quo[c][CH_W-1:0];
            end
        end
        result.red_out   = scaled[0];
        result.green_out = scaled[1];
        result.blue_out  = scaled[2];
    end

    assign result_valid = valid_reg[DIV_STAGES-1];

endmodule

// ===== bench/rgb_unit_vector_normalize_tb.sv =====
`timescale 1ns / 100ps

module rgb_unit_vector_normalize_tb;

    import rgbn_pkg::*;

    // expected normalized pixels, in request order
    class norm_scoreboard;
        result_t expected_q[$];
        int      errors;
        int      results_seen;

        // floor of the length with 8 fractional bits, one root bit at a time
        function logic [ROOT_W-1:0] vector_length(logic [SUMSQ_W-1:0] sumsq);
            logic [63:0]       rad;
            logic [63:0]       trial;
            logic [ROOT_W-1:0] len;
            rad = 64'(sumsq) << (2 * FRAC_W);
            len = '0;
            for (int b = ROOT_W - 1; b >= 0; b--)
            begin
                trial = 64'(len | (ROOT_W'(1) << b));
                if (trial * trial <= rad)
                    len = trial[ROOT_W-1:0];
            end
            return len;
        endfunction

        // 255 * c / length, rounded half up, clipped at full scale
        function logic [CH_W-1:0] scale_channel(logic [CH_W-1:0] c,
                                                logic [ROOT_W-1:0] len);
            logic [63:0] num;
            logic [63:0] quo;
            if (len == '0)
                return '0;
            num = ((64'd2 * FULL_SCALE * c) << FRAC_W) + len;
            quo = num / (64'd2 * len);
            if (quo > FULL_SCALE)
                quo = FULL_SCALE;
            return quo[CH_W-1:0];
        endfunction

        function result_t normalize(pixel_t p);
            logic [SUMSQ_W-1:0] sumsq;
            logic [ROOT_W-1:0]  len;
            result_t            r;
            sumsq = SUMSQ_W'(p.red_in) * p.red_in + SUMSQ_W'(p.green_in) * p.green_in
                  + SUMSQ_W'(p.blue_in) * p.blue_in;
            len = vector_length(sumsq);
            r.red_out   = scale_channel(p.red_in, len);
            r.green_out = scale_channel(p.green_in, len);
            r.blue_out  = scale_channel(p.blue_in, len);
            return r;
        endfunction

        function void note_pixel(pixel_t p);
            expected_q = {expected_q, normalize(p)};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with no request pending", results_seen));
                return;
            end
            want = expected_q.pop_front();
            if (got.red_out !== want.red_out)
                report($sformatf("result %0d red_out %0d, want %0d",
                                 results_seen, got.red_out, want.red_out));
            if (got.green_out !== want.green_out)
                report($sformatf("result %0d green_out %0d, want %0d",
                                 results_seen, got.green_out, want.green_out));
            if (got.blue_out !== want.blue_out)
                report($sformatf("result %0d blue_out %0d, want %0d",
                                 results_seen, got.blue_out, want.blue_out));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    pixel_valid;
    logic    pixel_ready;
    pixel_t  pixel;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    norm_scoreboard sb = new();
    bit             quiet;

    rgb_unit_vector_normalize dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // channel level biased toward the ends of the range
    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return CH_W'($urandom_range(1, 3));
            3: return CH_W'($urandom_range(252, 254));
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel request, with an optional idle gap ahead of it
    task send_rgb(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                  input logic [CH_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid     = 1'b1;
        pixel.red_in    = r;
        pixel.green_in  = g;
        pixel.blue_in   = b;
        do
            @(posedge clk);
        while (!pixel_ready);
        @(negedge clk);
    endtask

    // accepted requests and results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                sb.note_pixel(pixel);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // result side back-pressure
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int hold;
            hold = pick_gap();
            if (hold > 0)
            begin
                result_ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            result_ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // main sequence
    initial
    begin
        logic [CH_W-1:0] lv [3];
        int              big;
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        quiet       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: black, white, pure primaries, one-dominant, bit patterns
        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0,   8'd0);
        send_rgb(8'd0,   8'd255, 8'd0);
        send_rgb(8'd0,   8'd0,   8'd255);
        send_rgb(8'd1,   8'd0,   8'd0);
        send_rgb(8'd0,   8'd1,   8'd0);
        send_rgb(8'd0,   8'd0,   8'd1);
        send_rgb(8'd1,   8'd1,   8'd1);
        send_rgb(8'd255, 8'd1,   8'd1);
        send_rgb(8'd1,   8'd255, 8'd0);
        send_rgb(8'd0,   8'd1,   8'd255);
        send_rgb(8'd200, 8'd1,   8'd0);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd170, 8'd85,  8'd170);
        send_rgb(8'd85,  8'd170, 8'd85);
        send_rgb(8'd254, 8'd254, 8'd254);
        send_rgb(8'd3,   8'd4,   8'd0);
        send_rgb(8'd255, 8'd255, 8'd0);
        send_rgb(8'd1,   8'd2,   8'd2);
        send_rgb(8'd0,   8'd0,   8'd0);

        // random pixels, with one back-to-back stretch in the middle
        for (int i = 0; i < 1250; i++)
        begin
            quiet = (i >= 500 && i < 650);
            if ($urandom_range(0, 3) == 0)
            begin
                // one strong channel over faint others
                big = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++)
                    lv[c] = (c == big) ? CH_W'($urandom_range(200, 255))
                                       : CH_W'($urandom_range(0, 4));
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                    lv[c] = pick_level();
            end
            send_rgb(lv[0], lv[1], lv[2]);
        end
        quiet       = 1'b0;
        pixel_valid = 1'b0;

        // drain, then allow for any stray result
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("rgb_unit_vector_normalize test passed");
        else
            $display("rgb_unit_vector_normalize test failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #10_000_000;
        $display("[%0t] timeout, %0d results still pending", $realtime, sb.pending());
        $display("rgb_unit_vector_normalize test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rgbn_pkg.sv
rtl/core/rgbn_sumsq.sv
rtl/core/rgbn_sqrt.sv
rtl/core/rgbn_div.sv
rtl/core/rgb_unit_vector_normalize.sv
bench/rgb_unit_vector_normalize_tb.sv
